/* hdl/rpe_pkg.sv */
`default_nettype none

package rpe_pkg;

    // largest opcode buffer that a patch may address
    localparam int MAX_OPCODE_BYTES = 16;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // patch kinds
    localparam logic [3:0] CMD_UBYTE      = 4'd0;
    localparam logic [3:0] CMD_SBYTE      = 4'd1;
    localparam logic [3:0] CMD_HIGH_OFS   = 4'd2;
    localparam logic [3:0] CMD_BYTE2WORD  = 4'd3;
    localparam logic [3:0] CMD_SBYTE2WORD = 4'd4;
    localparam logic [3:0] CMD_BYTE2PTR   = 4'd5;
    localparam logic [3:0] CMD_SBYTE2PTR  = 4'd6;
    localparam logic [3:0] CMD_PTR24      = 4'd7;
    localparam logic [3:0] CMD_WORD       = 4'd8;
    localparam logic [3:0] CMD_WORD_BE    = 4'd9;
    localparam logic [3:0] CMD_DWORD      = 4'd10;
    localparam logic [3:0] CMD_JR         = 4'd11;
    localparam logic [3:0] CMD_JRE        = 4'd12;
    localparam logic [3:0] CMD_ASSIGN     = 4'd13;
    localparam logic [3:0] CMD_UNDEF      = 4'd14;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WARN  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;
    localparam logic [1:0] ST_UNDEF = 2'd3;

    // one patch request
    typedef struct packed {
        logic        [3:0]  command;
        logic signed [31:0] expr_value;
        logic        [23:0] instr_address;
        logic        [4:0]  opcode_length;
        logic        [3:0]  patch_offset;
        logic        [4:0]  buffer_length;
    } t_patch_in;

    // one patch result
    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [3:0] write_mask;
        logic [1:0] status;
    } t_patch_out;

    // classified patch, handed from front to back
    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] bits;
        logic        ext;
        logic [1:0]  status;
        logic [2:0]  byte_count;
        logic [3:0]  offset;
        logic [4:0]  blen;
    } t_work;

endpackage

`default_nettype wire

/* hdl/relocation_patch_encoder.sv */
`default_nettype none

// Fix-up patch encoder. A request is taken at each clock edge where start is
// high and busy is low; its result passes the queue and the result register
// and appears on o_result with o_done high for one cycle. One request per
// cycle is sustained: the back end empties the front-to-back queue by one entry
// every cycle, so the queue never fills and busy stays low in normal operation.
// The result port cannot be stalled; take each result in the cycle o_done is high.
module relocation_patch_encoder #(
    parameter int MAX_OPCODE_BYTES = rpe_pkg::MAX_OPCODE_BYTES,
    parameter int QUEUE_DEPTH      = rpe_pkg::QUEUE_DEPTH
) (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                start,
    output var logic                busy,
    input  var rpe_pkg::t_patch_in  i_patch,
    output var logic                o_done,
    output var rpe_pkg::t_patch_out o_result
);
    import rpe_pkg::*;

    t_work front_work;
    t_work head_work;
    logic  q_empty;
    logic  q_full;
    logic  accept;

    assign busy   = q_full;
    assign accept = start && !q_full;

    // front: adjust and classify
    rpe_front #(
        .MAX_BYTES(MAX_OPCODE_BYTES)
    ) u_front (
        .i_patch(i_patch),
        .o_work (front_work)
    );

    // queue between front and back
    rpe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (front_work),
        .i_pop  (!q_empty),
        .o_data (head_work),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    // back: byte layout, mask and result register
    rpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_work  (head_work),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // each accepted transfer yields a result strobe after the queue and the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("result strobe missing after accepted transfer");

    // a range error writes nothing
    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_ERROR) |-> (o_result.write_mask == 4'd0))
        else $error("range error with nonzero write mask");

    // byte 3 reads as zero when its mask bit is clear
    a_masked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.write_mask[3]) |-> (o_result.byte_3 == 8'h00))
        else $error("unwritten byte not cleared");

endmodule

`default_nettype wire

/* hdl/rpe_front.sv */
`default_nettype none

module rpe_front #(
    parameter int MAX_BYTES = rpe_pkg::MAX_OPCODE_BYTES
) (
    input  var rpe_pkg::t_patch_in i_patch,
    output var rpe_pkg::t_work     o_work
);
    import rpe_pkg::*;

    localparam int         LP_CLAMP    = (MAX_BYTES < 31) ? MAX_BYTES : 31;
    localparam logic [4:0] LP_BLEN_MAX = 5'(LP_CLAMP);

    localparam logic signed [33:0] LP_M128   = -34'sd128;
    localparam logic signed [33:0] LP_P127   = 34'sd127;
    localparam logic signed [33:0] LP_P255   = 34'sd255;
    localparam logic signed [33:0] LP_M8000  = -34'sd32768;
    localparam logic signed [33:0] LP_P7FFF  = 34'sd32767;

    logic              rel;
    logic [24:0]       base;
    logic signed [33:0] v;
    logic              lt_m128;
    logic              gt_127;
    logic              gt_255;
    logic              lt_0;
    logic              hi_bad;
    logic              jre_bad;

    // relative jumps subtract address plus opcode size at full width
    assign rel  = (i_patch.command == CMD_JR) || (i_patch.command == CMD_JRE);
    assign base = rel ? ({1'b0, i_patch.instr_address} + {20'd0, i_patch.opcode_length})
                      : 25'd0;
    assign v    = {{2{i_patch.expr_value[31]}}, i_patch.expr_value} - $signed({9'd0, base});

    // range flags
    assign lt_m128 = v < LP_M128;
    assign gt_127  = v > LP_P127;
    assign gt_255  = v > LP_P255;
    assign lt_0    = v[33];
    assign hi_bad  = (v[15:8] != 8'h00) && (v[15:8] != 8'hff);
    assign jre_bad = (v < LP_M8000) || (v > LP_P7FFF);

    // classify kind into status and written byte count
    always_comb begin
        o_work.command    = i_patch.command;
        o_work.bits       = v[31:0];
        o_work.ext        = lt_0 | gt_127;
        o_work.offset     = i_patch.patch_offset;
        o_work.blen       = (i_patch.buffer_length > LP_BLEN_MAX) ? LP_BLEN_MAX
                                                                  : i_patch.buffer_length;
        o_work.status     = ST_OK;
        o_work.byte_count = 3'd0;
        unique case (i_patch.command)
            CMD_UBYTE: begin
                o_work.status     = (lt_m128 || gt_255) ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd1;
            end
            CMD_SBYTE: begin
                o_work.status     = (lt_m128 || gt_127) ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd1;
            end
            CMD_HIGH_OFS: begin
                o_work.status     = hi_bad ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd1;
            end
            CMD_BYTE2WORD: begin
                o_work.status     = (lt_0 || gt_255) ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd2;
            end
            CMD_SBYTE2WORD: begin
                o_work.status     = (lt_m128 || gt_127) ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd2;
            end
            CMD_BYTE2PTR: begin
                o_work.status     = (lt_0 || gt_255) ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd3;
            end
            CMD_SBYTE2PTR: begin
                o_work.status     = (lt_m128 || gt_127) ? ST_WARN : ST_OK;
                o_work.byte_count = 3'd3;
            end
            CMD_PTR24:   o_work.byte_count = 3'd3;
            CMD_WORD:    o_work.byte_count = 3'd2;
            CMD_WORD_BE: o_work.byte_count = 3'd2;
            CMD_DWORD:   o_work.byte_count = 3'd4;
            CMD_JR: begin
                o_work.status     = (lt_m128 || gt_127) ? ST_ERROR : ST_OK;
                o_work.byte_count = (lt_m128 || gt_127) ? 3'd0 : 3'd1;
            end
            CMD_JRE: begin
                o_work.status     = jre_bad ? ST_ERROR : ST_OK;
                o_work.byte_count = jre_bad ? 3'd0 : 3'd2;
            end
            CMD_ASSIGN: o_work.byte_count = 3'd0;
            default:    o_work.status     = ST_UNDEF;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/rpe_queue.sv */
`default_nettype none

module rpe_queue #(
    parameter int DEPTH = rpe_pkg::QUEUE_DEPTH
) (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var logic           i_push,
    input  var rpe_pkg::t_work i_data,
    input  var logic           i_pop,
    output var rpe_pkg::t_work o_data,
    output var logic           o_empty,
    output var logic           o_full
);
    import rpe_pkg::*;

    localparam int LP_PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LP_CW = $clog2(DEPTH + 1);
    localparam logic [LP_CW-1:0] LP_DEPTH = LP_CW'(DEPTH);
    localparam logic [LP_PW-1:0] LP_LAST  = LP_PW'(DEPTH - 1);

    t_work            r_mem [DEPTH];
    logic [LP_PW-1:0] r_wptr;
    logic [LP_PW-1:0] r_rptr;
    logic [LP_CW-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == LP_DEPTH);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LP_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LP_LAST) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + LP_CW'(do_push) - LP_CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

/* hdl/rpe_back.sv */
`default_nettype none

module rpe_back (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_valid,
    input  var rpe_pkg::t_work      i_work,
    output var logic                o_done,
    output var rpe_pkg::t_patch_out o_result
);
    import rpe_pkg::*;

    logic [7:0] raw [4];
    logic [7:0] ext_byte;
    logic [4:0] pos [4];
    logic [3:0] mask;
    t_patch_out n_result;
    logic       r_done;
    t_patch_out r_result;

    assign ext_byte = i_work.ext ? 8'hff : 8'h00;

    // byte layout per kind
    always_comb begin
        raw[0] = i_work.bits[7:0];
        raw[1] = 8'h00;
        raw[2] = 8'h00;
        raw[3] = 8'h00;
        unique case (i_work.command)
            CMD_SBYTE2WORD: raw[1] = ext_byte;
            CMD_SBYTE2PTR: begin
                raw[1] = ext_byte;
                raw[2] = ext_byte;
            end
            CMD_PTR24: begin
                raw[1] = i_work.bits[15:8];
                raw[2] = i_work.bits[23:16];
            end
            CMD_WORD, CMD_JRE: raw[1] = i_work.bits[15:8];
            CMD_WORD_BE: begin
                raw[0] = i_work.bits[15:8];
                raw[1] = i_work.bits[7:0];
            end
            CMD_DWORD: begin
                raw[1] = i_work.bits[15:8];
                raw[2] = i_work.bits[23:16];
                raw[3] = i_work.bits[31:24];
            end
            default: raw[1] = 8'h00;
        endcase
    end

    // mask: byte written by the kind and inside the buffer
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pos[i]  = {1'b0, i_work.offset} + 5'(i);
            mask[i] = (3'(i) < i_work.byte_count) && (pos[i] < i_work.blen);
        end
    end

    always_comb begin
        n_result.byte_0     = mask[0] ? raw[0] : 8'h00;
        n_result.byte_1     = mask[1] ? raw[1] : 8'h00;
        n_result.byte_2     = mask[2] ? raw[2] : 8'h00;
        n_result.byte_3     = mask[3] ? raw[3] : 8'h00;
        n_result.write_mask = mask;
        n_result.status     = i_work.status;
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* dv/tb_relocation_patch_encoder.sv */
`timescale 1ns / 1ps

module tb_relocation_patch_encoder;

    import rpe_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int NUM_RANDOM     = 400;
    localparam int MAX_GAP        = 17;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_patch_in  i_patch;
    logic       o_done;
    t_patch_out o_result;

    // encoded patches waiting for their result transfer
    t_patch_out pending_results[$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         no_gap_left;

    relocation_patch_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_patch  (i_patch),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // expected encoding of one patch request
    function automatic t_patch_out encode_patch(input t_patch_in p);
        longint          v;
        logic [31:0]     bits;
        logic [7:0]      ext;
        logic [3:0][7:0] b;
        logic [3:0]      mask;
        logic [1:0]      st;
        int              n;
        int              blen;
        t_patch_out      r;
        v    = longint'($signed(p.expr_value));
        blen = (p.buffer_length > MAX_OPCODE_BYTES) ? MAX_OPCODE_BYTES : int'(p.buffer_length);
        // relative jumps are measured from the end of the opcode
        if (p.command == CMD_JR || p.command == CMD_JRE) begin
            v = v - (longint'(p.instr_address) + longint'(p.opcode_length));
        end
        bits = v[31:0];
        ext  = (v < 0 || v > 127) ? 8'hff : 8'h00;
        b    = '0;
        mask = '0;
        st   = ST_OK;
        n    = 0;
        case (p.command)
            CMD_UBYTE: begin
                if (v < -128 || v > 255) st = ST_WARN;
                b[0] = bits[7:0];
                n = 1;
            end
            CMD_SBYTE: begin
                if (v < -128 || v > 127) st = ST_WARN;
                b[0] = bits[7:0];
                n = 1;
            end
            CMD_HIGH_OFS: begin
                if (bits[15:8] != 8'h00 && bits[15:8] != 8'hff) st = ST_WARN;
                b[0] = bits[7:0];
                n = 1;
            end
            CMD_BYTE2WORD: begin
                if (v < 0 || v > 255) st = ST_WARN;
                b[0] = bits[7:0];
                n = 2;
            end
            CMD_SBYTE2WORD: begin
                if (v < -128 || v > 127) st = ST_WARN;
                b[0] = bits[7:0];
                b[1] = ext;
                n = 2;
            end
            CMD_BYTE2PTR: begin
                if (v < 0 || v > 255) st = ST_WARN;
                b[0] = bits[7:0];
                n = 3;
            end
            CMD_SBYTE2PTR: begin
                if (v < -128 || v > 127) st = ST_WARN;
                b[0] = bits[7:0];
                b[1] = ext;
                b[2] = ext;
                n = 3;
            end
            CMD_PTR24: begin
                b[0] = bits[7:0];
                b[1] = bits[15:8];
                b[2] = bits[23:16];
                n = 3;
            end
            CMD_WORD: begin
                b[0] = bits[7:0];
                b[1] = bits[15:8];
                n = 2;
            end
            CMD_WORD_BE: begin
                b[0] = bits[15:8];
                b[1] = bits[7:0];
                n = 2;
            end
            CMD_DWORD: begin
                b = bits;
                n = 4;
            end
            CMD_JR: begin
                if (v < -128 || v > 127) begin
                    st = ST_ERROR;
                end else begin
                    b[0] = bits[7:0];
                    n = 1;
                end
            end
            CMD_JRE: begin
                if (v < -32768 || v > 32767) begin
                    st = ST_ERROR;
                end else begin
                    b[0] = bits[7:0];
                    b[1] = bits[15:8];
                    n = 2;
                end
            end
            CMD_ASSIGN: begin
                n = 0;
            end
            default: begin
                st = ST_UNDEF;
            end
        endcase
        // drop bytes not written or past the buffer end
        for (int i = 0; i < 4; i++) begin
            if (i < n && int'(p.patch_offset) + i < blen) begin
                mask[i] = 1'b1;
            end else begin
                b[i] = 8'h00;
            end
        end
        r.byte_0     = b[0];
        r.byte_1     = b[1];
        r.byte_2     = b[2];
        r.byte_3     = b[3];
        r.write_mask = mask;
        r.status     = st;
        return r;
    endfunction

    function automatic t_patch_in make_patch(input logic [3:0] cmd, input logic [31:0] value,
                                             input logic [23:0] addr, input logic [4:0] oplen,
                                             input logic [3:0] offset, input logic [4:0] blen);
        t_patch_in p;
        p.command       = cmd;
        p.expr_value    = value;
        p.instr_address = addr;
        p.opcode_length = oplen;
        p.patch_offset  = offset;
        p.buffer_length = blen;
        return p;
    endfunction

    // request transfer with a random lead-in gap, returns at the accepting edge
    task automatic send_patch(input t_patch_in p);
        int gap;
        if (no_gap_left > 0) begin
            gap = 0;
            no_gap_left--;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 7) == 0) no_gap_left = $urandom_range(4, 24);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_patch <= p;
        do @(posedge i_clk); while (!(start && !busy));
    endtask

    // result check, expectation capture and watchdog
    always @(posedge i_clk) begin
        t_patch_out exp_result;
        if (i_rst_n) begin
            if (start && !busy) pending_results = {pending_results, encode_patch(i_patch)};
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result transfer: %h", o_result);
                    end
                end else begin
                    exp_result = pending_results.pop_front();
                    if (o_result.byte_0 !== exp_result.byte_0 ||
                        o_result.byte_1 !== exp_result.byte_1 ||
                        o_result.byte_2 !== exp_result.byte_2 ||
                        o_result.byte_3 !== exp_result.byte_3 ||
                        o_result.write_mask !== exp_result.write_mask ||
                        o_result.status !== exp_result.status) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch: exp bytes %h %h %h %h mask %b status %0d",
                                     exp_result.byte_0, exp_result.byte_1, exp_result.byte_2,
                                     exp_result.byte_3, exp_result.write_mask,
                                     exp_result.status);
                            $display("          got bytes %h %h %h %h mask %b status %0d",
                                     o_result.byte_0, o_result.byte_1, o_result.byte_2,
                                     o_result.byte_3, o_result.write_mask, o_result.status);
                        end
                    end
                end
            end
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // every kind, including assignment and both undefined codes, at value extremes
    task automatic test_each_kind();
        for (int cmd = 0; cmd < 16; cmd++) begin
            send_patch(make_patch(cmd[3:0], cmd[0] ? 32'h8000_0000 : 32'h7fff_ffff,
                                  24'h000000, 5'd0, 4'd0, 5'd16));
        end
    endtask

    // jr on both sides of both its range limits, jre in and out of its range
    task automatic test_relative_jumps();
        send_patch(make_patch(CMD_JR, 32'h0000_0181, 24'h000100, 5'd2, 4'd3, 5'd16));
        send_patch(make_patch(CMD_JR, 32'h0000_0182, 24'h000100, 5'd2, 4'd3, 5'd16));
        send_patch(make_patch(CMD_JR, 32'h0000_0082, 24'h000100, 5'd2, 4'd3, 5'd16));
        send_patch(make_patch(CMD_JR, 32'h0000_0081, 24'h000100, 5'd2, 4'd3, 5'd16));
        send_patch(make_patch(CMD_JRE, 32'h8000_0000, 24'hffffff, 5'd16, 4'd1, 5'd16));
        send_patch(make_patch(CMD_JRE, 32'h0100_800e, 24'hffffff, 5'd16, 4'd0, 5'd1));
    endtask

    // patches clipped at the buffer end, empty and oversized buffers
    task automatic test_buffer_edges();
        send_patch(make_patch(CMD_DWORD, 32'h1234_5678, 24'h000000, 5'd0, 4'd14, 5'd16));
        send_patch(make_patch(CMD_SBYTE2PTR, 32'hffff_ffff, 24'h000000, 5'd0, 4'd15, 5'd31));
        send_patch(make_patch(CMD_WORD_BE, 32'h0000_abcd, 24'h000000, 5'd0, 4'd0, 5'd0));
    endtask

    function automatic longint pick_limit();
        case ($urandom_range(0, 11))
            0:       return -32769;
            1:       return -32768;
            2:       return -129;
            3:       return -128;
            4:       return -1;
            5:       return 0;
            6:       return 127;
            7:       return 128;
            8:       return 255;
            9:       return 256;
            10:      return 32767;
            default: return 32768;
        endcase
    endfunction

    // random patches, values mostly near the range limits of each kind
    task automatic test_random_patches();
        t_patch_in p;
        longint    value;
        longint    base;
        for (int k = 0; k < NUM_RANDOM; k++) begin
            p.command       = 4'($urandom_range(0, 15));
            p.opcode_length = 5'($urandom_range(0, 16));
            p.patch_offset  = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:       p.instr_address = 24'($urandom_range(0, 255));
                1:       p.instr_address = 24'(24'hffffff - $urandom_range(0, 255));
                default: p.instr_address = 24'($urandom_range(0, 24'hffffff));
            endcase
            if ($urandom_range(0, 4) == 0) begin
                p.buffer_length = 5'($urandom_range(17, 31));
            end else begin
                p.buffer_length = 5'($urandom_range(0, 16));
            end
            base = 0;
            if ((p.command == CMD_JR || p.command == CMD_JRE) && $urandom_range(0, 5) != 0) begin
                base = longint'(p.instr_address) + longint'(p.opcode_length);
            end
            case ($urandom_range(0, 4))
                0:       value = longint'($signed($urandom()));
                1:       value = base + $urandom_range(0, 600) - 300;
                2:       value = base + longint'($signed({{16{1'b0}},
                                    $urandom_range(0, 2) == 0 ? 8'h00 :
                                    ($urandom_range(0, 1) == 0 ? 8'hff : 8'($urandom())),
                                    8'($urandom())}));
                default: value = base + pick_limit() + $urandom_range(0, 2) - 1;
            endcase
            p.expr_value = value[31:0];
            send_patch(p);
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_patch        <= '0;
        no_gap_left    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_each_kind();
        test_relative_jumps();
        test_buffer_edges();
        test_random_patches();
        start <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
